// ----- rtl/core/bvcl_pkg.sv -----
// bvcl_pkg: shared widths, voltage/percent table, controller states and
// the command/status structs between controller and datapath
// no dependencies
package bvcl_pkg;

  localparam int MV_W        = 13;
  localparam int PCT_W       = 7;
  localparam int PT_AVAIL    = 13;
  localparam int PT_IDX_W    = 4;
  localparam int TABLE_POINTS_DEF = 13;
  localparam int DIV_W       = MV_W + PCT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [MV_W-1:0] THRESH_RESET = 13'd2500;

  // register select bit of paddr (paddr[2])
  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SRCH,
    ST_MUL,
    ST_DIV,
    ST_LEVEL,
    ST_DONE
  } bvcl_state_t;

  typedef struct packed {
    logic take;      // good sample: update filter and presence
    logic clamp;     // write level for absent or clamped voltage
    logic seg_next;  // advance segment search
    logic mul;       // load segment product, divisor and base
    logic div_step;  // one restoring divide step
    logic level;     // write interpolated level
    logic load_out;  // copy state into output register
  } bvcl_cmd_t;

  typedef struct packed {
    logic clamp_hit;
    logic seg_hit;
    logic div_last;
    logic out_free;
  } bvcl_sts_t;

  function automatic logic [MV_W-1:0] pt_mv(input logic [PT_IDX_W-1:0] idx);
    logic [MV_W-1:0] v;
    unique case (idx)
      4'd0:    v = 13'd2850;
      4'd1:    v = 13'd3000;
      4'd2:    v = 13'd3200;
      4'd3:    v = 13'd3300;
      4'd4:    v = 13'd3400;
      4'd5:    v = 13'd3500;
      4'd6:    v = 13'd3600;
      4'd7:    v = 13'd3700;
      4'd8:    v = 13'd3800;
      4'd9:    v = 13'd3900;
      4'd10:   v = 13'd4000;
      4'd11:   v = 13'd4100;
      4'd12:   v = 13'd4200;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] pt_pct(input logic [PT_IDX_W-1:0] idx);
    logic [PCT_W-1:0] p;
    unique case (idx)
      4'd0:    p = 7'd0;
      4'd1:    p = 7'd2;
      4'd2:    p = 7'd5;
      4'd3:    p = 7'd10;
      4'd4:    p = 7'd15;
      4'd5:    p = 7'd22;
      4'd6:    p = 7'd30;
      4'd7:    p = 7'd42;
      4'd8:    p = 7'd55;
      4'd9:    p = 7'd70;
      4'd10:   p = 7'd82;
      4'd11:   p = 7'd92;
      4'd12:   p = 7'd100;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/bvcl_ctrl.sv -----
// bvcl_ctrl: sequencer for one sample (filter, clamp, search, divide, output)
// depends on bvcl_pkg
module bvcl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_read_ok,
  input  bvcl_pkg::bvcl_sts_t sts,
  output logic                in_stall,
  output bvcl_pkg::bvcl_cmd_t cmd
);

  bvcl_pkg::bvcl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bvcl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      bvcl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = in_read_ok;
          state_nxt = in_read_ok ? bvcl_pkg::ST_CLAMP : bvcl_pkg::ST_DONE;
        end
      end
      bvcl_pkg::ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = sts.clamp_hit ? bvcl_pkg::ST_DONE : bvcl_pkg::ST_SRCH;
      end
      bvcl_pkg::ST_SRCH: begin
        if (sts.seg_hit) begin
          state_nxt = bvcl_pkg::ST_MUL;
        end else begin
          cmd.seg_next = 1'b1;
        end
      end
      bvcl_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = bvcl_pkg::ST_DIV;
      end
      bvcl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = bvcl_pkg::ST_LEVEL;
        end
      end
      bvcl_pkg::ST_LEVEL: begin
        cmd.level = 1'b1;
        state_nxt = bvcl_pkg::ST_DONE;
      end
      bvcl_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = bvcl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bvcl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/bvcl_dp.sv -----
// bvcl_dp: filter state, segment search, product, restoring divider and
// output register; driven by bvcl_ctrl commands, depends on bvcl_pkg
module bvcl_dp #(
  parameter int TABLE_POINTS = bvcl_pkg::TABLE_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bvcl_pkg::bvcl_cmd_t           cmd,
  output bvcl_pkg::bvcl_sts_t           sts,
  input  logic [bvcl_pkg::MV_W-1:0]     in_sample_mv,
  input  logic [bvcl_pkg::MV_W-1:0]     threshold_mv,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [bvcl_pkg::MV_W-1:0]     out_filtered_mv,
  output logic [bvcl_pkg::PCT_W-1:0]    out_charge_pct,
  output logic                          out_present,
  output logic                          out_valid_res
);

  localparam int NPTS = (TABLE_POINTS > bvcl_pkg::PT_AVAIL) ? bvcl_pkg::PT_AVAIL :
                        (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;
  localparam int IDX_W = $clog2(NPTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NPTS - 1);
  localparam int MV_W  = bvcl_pkg::MV_W;
  localparam int PCT_W = bvcl_pkg::PCT_W;
  localparam int DIV_W = bvcl_pkg::DIV_W;
  localparam int CNT_W = bvcl_pkg::DIV_CNT_W;

  // state
  logic [MV_W-1:0]  filt_r;
  logic             have_r;
  logic             present_r;
  logic [PCT_W-1:0] level_r;

  // search and divide
  logic [IDX_W-1:0] seg_idx_r;
  logic [DIV_W-1:0] quo_r;
  logic [MV_W-1:0]  rem_r;
  logic [MV_W-1:0]  div_r;
  logic [PCT_W-1:0] base_r;
  logic             flat_r;
  logic [CNT_W-1:0] cnt_r;

  // output register
  logic             out_valid_r;
  logic [MV_W-1:0]  out_filt_r;
  logic [PCT_W-1:0] out_level_r;
  logic             out_present_r;
  logic             out_valid_res_r;

  logic [MV_W+1:0]  filt_sum;
  logic [MV_W-1:0]  filt_nxt;
  logic [bvcl_pkg::PT_IDX_W-1:0] hi_idx, lo_idx;
  logic [MV_W-1:0]  hv, lv, mv_first, mv_last;
  logic [PCT_W-1:0] hp, lp, span;
  logic [MV_W-1:0]  delta;
  logic [MV_W:0]    trial;
  logic             trial_ge;

  always_comb begin
    filt_sum = (MV_W+2)'(filt_r) * (MV_W+2)'(3) + (MV_W+2)'(in_sample_mv)
             + (MV_W+2)'(2);
    filt_nxt = have_r ? filt_sum[MV_W+1:2] : in_sample_mv;
  end

  always_comb begin
    hi_idx   = bvcl_pkg::PT_IDX_W'(seg_idx_r);
    lo_idx   = bvcl_pkg::PT_IDX_W'(IDX_W'(seg_idx_r - 1'b1));
    hv       = bvcl_pkg::pt_mv(hi_idx);
    lv       = bvcl_pkg::pt_mv(lo_idx);
    hp       = bvcl_pkg::pt_pct(hi_idx);
    lp       = bvcl_pkg::pt_pct(lo_idx);
    span     = hp - lp;
    delta    = filt_r - lv;
    mv_first = bvcl_pkg::pt_mv('0);
    mv_last  = bvcl_pkg::pt_mv(bvcl_pkg::PT_IDX_W'(LAST_IDX));
    trial    = {rem_r, quo_r[DIV_W-1]};
    trial_ge = trial >= {1'b0, div_r};
  end

  always_comb begin
    sts.clamp_hit = !present_r || (filt_r <= mv_first) || (filt_r >= mv_last);
    sts.seg_hit   = filt_r <= hv;
    sts.div_last  = cnt_r == CNT_W'(DIV_W - 1);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r    <= '0;
      have_r    <= 1'b0;
      present_r <= 1'b0;
      level_r   <= '0;
    end else begin
      if (cmd.take) begin
        filt_r    <= filt_nxt;
        have_r    <= 1'b1;
        present_r <= filt_nxt >= threshold_mv;
      end
      if (cmd.clamp) begin
        priority if (!present_r) begin
          level_r <= '0;
        end else if (filt_r <= mv_first) begin
          level_r <= bvcl_pkg::pt_pct('0);
        end else begin
          level_r <= bvcl_pkg::pt_pct(bvcl_pkg::PT_IDX_W'(LAST_IDX));
        end
      end
      if (cmd.level) begin
        level_r <= flat_r ? '0 : PCT_W'(base_r + quo_r[PCT_W-1:0]);
      end
    end
  end

  // segment search and restoring divide, one step per cycle
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      seg_idx_r <= IDX_W'(1);
    end else if (cmd.seg_next) begin
      seg_idx_r <= IDX_W'(seg_idx_r + 1'b1);
    end
    if (cmd.mul) begin
      quo_r  <= DIV_W'(delta * span);
      div_r  <= hv - lv;
      base_r <= lp;
      flat_r <= hv <= lv;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? MV_W'(trial - {1'b0, div_r}) : trial[MV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], trial_ge};
      cnt_r <= CNT_W'(cnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_filt_r      <= filt_r;
      out_level_r     <= level_r;
      out_present_r   <= present_r;
      out_valid_res_r <= have_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_filtered_mv = out_filt_r;
  assign out_charge_pct  = out_level_r;
  assign out_present     = out_present_r;
  assign out_valid_res   = out_valid_res_r;

endmodule

// ----- rtl/core/battery_voltage_to_charge_level_core.sv -----
// battery_voltage_to_charge_level_core: top level with threshold register,
// controller and datapath; depends on bvcl_pkg, bvcl_ctrl, bvcl_dp
//
// Battery charge-level estimator. Each input beat carries one voltage sample
// in mV and a read_ok flag; each accepted beat gives exactly one result beat
// holding the filtered voltage, the charge level, the present flag and a
// flag that is set once a good sample was seen. The first good sample is
// taken as is, later ones are filtered as (3*old + new + 2)/4. A failed read
// leaves all state alone and just reports it again. The threshold register
// (byte address 0) takes effect at the next good sample. One sample is in
// work at a time: a failed read goes straight to the output load, a good
// sample that is absent or outside the table passes the clamp step first,
// and a sample inside the table passes clamp, the one-entry-per-cycle
// segment search (segment 1 .. points-1), product, the restoring divider
// (one quotient bit per cycle) and the level write before the load.
// The next beat is taken the cycle after the result is loaded, even while
// that result still waits in the output register.
module battery_voltage_to_charge_level_core #(
  parameter int TABLE_POINTS = bvcl_pkg::TABLE_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beat channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bvcl_pkg::MV_W-1:0]          in_sample_mv,
  input  logic                               in_read_ok,
  // result beat channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bvcl_pkg::MV_W-1:0]          out_filtered_mv,
  output logic [bvcl_pkg::PCT_W-1:0]         out_charge_pct,
  output logic                               out_present,
  output logic                               out_valid_res,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bvcl_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bvcl_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bvcl_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  bvcl_pkg::bvcl_cmd_t cmd;
  bvcl_pkg::bvcl_sts_t sts;

  logic [bvcl_pkg::MV_W-1:0] thresh_r;
  logic                      cfg_wr;

  // zero wait state port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // threshold register, only the register select bit is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= bvcl_pkg::THRESH_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == bvcl_pkg::REG_THRESHOLD)) begin
      thresh_r <= cfg_pwdata[bvcl_pkg::MV_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == bvcl_pkg::REG_THRESHOLD) begin
      cfg_prdata = bvcl_pkg::CFG_DATA_W'(thresh_r);
    end
  end

  // sequencer
  bvcl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_read_ok (in_read_ok),
    .sts        (sts),
    .in_stall   (in_stall),
    .cmd        (cmd)
  );

  // filter, table interpolation and output register
  bvcl_dp #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample_mv      (in_sample_mv),
    .threshold_mv      (thresh_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_filtered_mv   (out_filtered_mv),
    .out_charge_pct    (out_charge_pct),
    .out_present       (out_present),
    .out_valid_res     (out_valid_res)
  );

  // one sample in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input beat taken while previous sample still in work");

  // level stays within the table range
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_pct <= 7'd100))
    else $error("level above 100 percent");

  // absent battery reports zero level
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_present) |-> (out_charge_pct == '0))
    else $error("nonzero level while absent");

  // before any good sample the result is all zero
  a_no_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      ((out_filtered_mv == '0) && !out_present && (out_charge_pct == '0)))
    else $error("nonzero result before first good sample");

endmodule

// ----- tb/bvcl_charge_checker.sv -----
// bvcl_charge_checker: watches the sample, result and threshold ports of the
// charge-level core, predicts each result beat and compares it in order
// depends on bvcl_pkg
module bvcl_charge_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [bvcl_pkg::MV_W-1:0]          in_sample_mv,
  input  logic                               in_read_ok,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [bvcl_pkg::MV_W-1:0]          out_filtered_mv,
  input  logic [bvcl_pkg::PCT_W-1:0]         out_charge_pct,
  input  logic                               out_present,
  input  logic                               out_valid_res,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bvcl_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bvcl_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  input  logic                               cfg_pready,
  output int                                 mismatch_count,
  output int                                 results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SOC_POINTS = 13;
  localparam int MAX_REPORTS = 10;
  localparam int MV_W  = bvcl_pkg::MV_W;
  localparam int PCT_W = bvcl_pkg::PCT_W;

  typedef struct packed {
    logic [MV_W-1:0]  filtered_mv;
    logic [PCT_W-1:0] charge_pct;
    logic             present;
    logic             valid_res;
  } charge_result_t;

  int soc_mv  [SOC_POINTS] = '{2850, 3000, 3200, 3300, 3400, 3500, 3600,
                               3700, 3800, 3900, 4000, 4100, 4200};
  int soc_pct [SOC_POINTS] = '{0, 2, 5, 10, 15, 22, 30, 42, 55, 70, 82, 92, 100};

  // mirrored block state
  logic [MV_W-1:0]  threshold_mv;
  logic [MV_W-1:0]  filt_mv;
  logic             have_sample;
  logic [PCT_W-1:0] level_q;
  logic             present_q;

  charge_result_t   expected_results [$];
  int               fail_total;

  // piecewise-linear lookup, clamped at both ends, floor inside a segment
  function automatic logic [PCT_W-1:0] charge_level_of(
    input logic [MV_W-1:0] mv
  );
    int v;
    int seg;
    int lvl;
    v = int'(mv);
    if (v <= soc_mv[0]) begin
      lvl = soc_pct[0];
    end else if (v >= soc_mv[SOC_POINTS-1]) begin
      lvl = soc_pct[SOC_POINTS-1];
    end else begin
      lvl = soc_pct[SOC_POINTS-1];
      // walk down so the lowest matching segment wins
      for (seg = SOC_POINTS - 1; seg >= 1; seg--) begin
        if (v <= soc_mv[seg]) begin
          if (soc_mv[seg] > soc_mv[seg-1])
            lvl = soc_pct[seg-1] + ((v - soc_mv[seg-1]) *
                  (soc_pct[seg] - soc_pct[seg-1])) / (soc_mv[seg] - soc_mv[seg-1]);
          else
            lvl = 0;
        end
      end
    end
    return lvl[PCT_W-1:0];
  endfunction

  always @(posedge clk) begin
    int             acc;
    charge_result_t got;
    charge_result_t want;
    if (!rst_n) begin
      threshold_mv = bvcl_pkg::THRESH_RESET;
      filt_mv      = '0;
      have_sample  = 1'b0;
      level_q      = '0;
      present_q    = 1'b0;
      fail_total   = 0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == bvcl_pkg::REG_THRESHOLD)
        threshold_mv = cfg_pwdata[MV_W-1:0];

      if (out_valid && !out_stall) begin
        got = '{out_filtered_mv, out_charge_pct, out_present, out_valid_res};
        if (expected_results.size() == 0) begin
          fail_total++;
          if (fail_total <= MAX_REPORTS)
            $display({"%0t: result beat with nothing pending: filtered_mv=%0d",
                      " level=%0d present=%0b valid_res=%0b"},
                     $realtime, got.filtered_mv, got.charge_pct, got.present,
                     got.valid_res);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
              $display({"%0t: expected filtered_mv=%0d level=%0d present=%0b",
                        " valid_res=%0b, got filtered_mv=%0d level=%0d",
                        " present=%0b valid_res=%0b"},
                       $realtime, want.filtered_mv, want.charge_pct, want.present,
                       want.valid_res, got.filtered_mv, got.charge_pct, got.present,
                       got.valid_res);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_read_ok) begin
          if (!have_sample) begin
            filt_mv = in_sample_mv;
          end else begin
            acc     = (3 * int'(filt_mv) + int'(in_sample_mv) + 2) / 4;
            filt_mv = acc[MV_W-1:0];
          end
          have_sample = 1'b1;
          present_q   = (filt_mv >= threshold_mv);
          level_q     = present_q ? charge_level_of(filt_mv) : '0;
        end
        expected_results.push_back('{filt_mv, level_q, present_q, have_sample});
      end
    end
    mismatch_count  <= fail_total;
    results_pending <= expected_results.size();
  end

endmodule

// ----- tb/tb_battery_voltage_to_charge_level_core.sv -----
// tb_battery_voltage_to_charge_level_core: stimulus and verdict for the
// charge-level core; depends on bvcl_pkg, the core and bvcl_charge_checker
module tb_battery_voltage_to_charge_level_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MV_W       = bvcl_pkg::MV_W;
  localparam int PCT_W      = bvcl_pkg::PCT_W;
  localparam int CFG_ADDR_W = bvcl_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = bvcl_pkg::CFG_DATA_W;

  // cycles with no beat on either channel before the run is called hung
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 150;
  localparam int HOLD_AT_FIRST = 200;
  localparam int HOLD_AT_NEXT  = 650;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_BEATS   = 150;
  localparam int NUM_PHASES    = 6;
  localparam int MV_MAX        = 8191;

  localparam logic [CFG_ADDR_W-1:0] THRESH_ADDR = {bvcl_pkg::REG_THRESHOLD, 2'b00};

  logic                  clk;
  logic                  rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MV_W-1:0]       in_sample_mv = '0;
  logic                  in_read_ok = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MV_W-1:0]       out_filtered_mv;
  logic [PCT_W-1:0]      out_charge_pct;
  logic                  out_present;
  logic                  out_valid_res;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int                    mismatch_count;
  int                    results_pending;
  int                    idle_cycles = 0;
  int                    rx_beats = 0;
  // when set, neither side inserts random gaps
  bit                    no_idle = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  battery_voltage_to_charge_level_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_mv      (in_sample_mv),
    .in_read_ok        (in_read_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_filtered_mv   (out_filtered_mv),
    .out_charge_pct    (out_charge_pct),
    .out_present       (out_present),
    .out_valid_res     (out_valid_res),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  bvcl_charge_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_mv      (in_sample_mv),
    .in_read_ok        (in_read_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_filtered_mv   (out_filtered_mv),
    .out_charge_pct    (out_charge_pct),
    .out_present       (out_present),
    .out_valid_res     (out_valid_res),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_pready        (cfg_pready),
    .mismatch_count    (mismatch_count),
    .results_pending   (results_pending)
  );

  // offer one sample beat; returns right after the edge that took it, with
  // valid still high so a back-to-back beat needs no second assignment
  task automatic offer_sample(input logic [MV_W-1:0] mv, input logic ok);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_mv <= mv;
    in_read_ok   <= ok;
    // stall is settled by the falling edge, so check there and take the beat
    // at the following rising edge
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // setup and access cycle; upper data bits are random junk
  task automatic write_present_threshold(input logic [MV_W-1:0] mv);
    logic [CFG_DATA_W-1:0] word;
    word             = $urandom;
    word[MV_W-1:0]   = mv;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= THRESH_ADDR;
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // result side: random stall before each beat, plus two long hold-offs so
  // the core fills up and pushes back on the sample side
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (rx_beats == HOLD_AT_FIRST || rx_beats == HOLD_AT_NEXT)
        hold = HOLD_CYCLES;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      rx_beats++;
    end
  end

  // hang detector: counts cycles with no beat on either channel
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int              phase;
    int              n;
    int              run_left;
    int              target_mv;
    int              pick;
    int              mv;
    logic [MV_W-1:0] phase_thresh [NUM_PHASES];

    // threshold per random phase: both extremes, the table ends, a random one, mid-table
    phase_thresh[0] = '0;
    phase_thresh[1] = 13'(MV_MAX);
    phase_thresh[2] = 13'd2850;
    phase_thresh[3] = 13'd4200;
    phase_thresh[4] = 13'($urandom_range(0, MV_MAX));
    phase_thresh[5] = 13'd3500;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // top threshold: only a filter sitting at full scale counts as present
    write_present_threshold(13'(MV_MAX));
    // failed reads before any good sample report all zeros
    offer_sample('0, 1'b0);
    offer_sample(13'(MV_MAX), 1'b0);
    // first good sample is taken as is, at full scale: present, level 100
    offer_sample(13'(MV_MAX), 1'b1);
    offer_sample(13'(MV_MAX), 1'b1);
    offer_sample('0, 1'b0);
    offer_sample(13'd8190, 1'b1);
    // big drop: filter falls below threshold, level forced to 0
    offer_sample('0, 1'b1);
    wait_results_drained();

    // back to the reset value; a failed read must keep the old present flag
    write_present_threshold(bvcl_pkg::THRESH_RESET);
    offer_sample('0, 1'b0);
    offer_sample(13'd4200, 1'b1);
    // walk the filter down through the table and below its bottom end
    offer_sample(13'd3000, 1'b1);
    offer_sample(13'd3000, 1'b1);
    offer_sample(13'd3000, 1'b1);
    offer_sample(13'd3000, 1'b1);
    offer_sample(13'd2850, 1'b1);
    offer_sample(13'd2850, 1'b1);
    offer_sample(13'd2850, 1'b1);
    offer_sample('0, 1'b1);
    offer_sample('0, 1'b1);
    offer_sample('0, 1'b1);
    offer_sample(13'h1555, 1'b0);
    offer_sample(13'h0AAA, 1'b1);
    wait_results_drained();

    // random phases: mostly runs of samples near a target inside or just
    // around the table, the rest full-range noise and extremes
    run_left  = 0;
    target_mv = 3500;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      write_present_threshold(phase_thresh[phase]);
      no_idle = (phase == 1 || phase == 4);
      // threshold takes effect only at the next good sample
      offer_sample(13'($urandom_range(0, MV_MAX)), 1'b0);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if (run_left == 0) begin
          target_mv = $urandom_range(2700, 4350);
          run_left  = $urandom_range(10, 30);
        end
        run_left--;
        pick = $urandom_range(0, 9);
        if (pick < 7)
          mv = target_mv + $urandom_range(0, 120) - 60;
        else if (pick == 7)
          mv = $urandom_range(0, MV_MAX);
        else
          mv = ($urandom_range(0, 1) != 0) ? MV_MAX : 0;
        offer_sample(13'(mv), ($urandom_range(0, 7) != 0));
      end
      wait_results_drained();
    end
    no_idle = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
